FILE: rtl/yrd_pkg.sv
// shared types, coefficients and helper functions for the yuyv to rgb converter
package yrd_pkg;

	localparam int unsigned ProdW  = 26;
	localparam int unsigned WholeW = ProdW - 16;
	localparam int unsigned ScaleW = 17;
	localparam int unsigned GainW  = 9;

	localparam logic [GainW-1:0] GainReset = 9'd220;

	localparam logic signed [ProdW-1:0] CoefKr  = 26'sd89831;
	localparam logic signed [ProdW-1:0] CoefKgv = 26'sd45744;
	localparam logic signed [ProdW-1:0] CoefKgu = 26'sd22127;
	localparam logic signed [ProdW-1:0] CoefKb  = 26'sd113538;

	typedef struct packed {
		logic signed [ProdW-1:0] kr_v;
		logic signed [ProdW-1:0] kgv_v;
		logic signed [ProdW-1:0] kgu_u;
		logic signed [ProdW-1:0] kb_u;
	} prod_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct packed {
		logic [ScaleW-1:0] blue;
		logic [ScaleW-1:0] green;
		logic [ScaleW-1:0] red;
	} scaled_t;

	function automatic logic [7:0] clamp8(input logic signed [WholeW-1:0] whole);
		logic [7:0] res;
		if (whole < 0) begin
			res = 8'd0;
		end else if (whole > 10'sd255) begin
			res = 8'd255;
		end else begin
			res = whole[7:0];
		end
		return res;
	endfunction

	function automatic logic [7:0] sat8(input logic [ScaleW-1:0] prod);
		logic [7:0] res;
		if (prod[ScaleW-1]) begin
			res = 8'd255;
		end else begin
			res = prod[ScaleW-2:8];
		end
		return res;
	endfunction

endpackage

FILE: rtl/yrd_pixel.sv
// per-pixel color sums, floor and clamp, gain multiply and saturation (stages 2 to 4)
module yrd_pixel (
	input  logic                        clk,
	input  logic                        en,
	input  logic [7:0]                  luma,
	input  yrd_pkg::prod_t              prod,
	input  logic [yrd_pkg::GainW-1:0]   gain,
	output yrd_pkg::rgb_t               rgb
);

	logic signed [yrd_pkg::ProdW-1:0] base;
	logic signed [yrd_pkg::ProdW-1:0] sum_r;
	logic signed [yrd_pkg::ProdW-1:0] sum_g;
	logic signed [yrd_pkg::ProdW-1:0] sum_b;
	logic [yrd_pkg::ScaleW-1:0]       gain_x;

	yrd_pkg::rgb_t    clamp_s2;
	yrd_pkg::scaled_t scaled_s3;
	yrd_pkg::rgb_t    rgb_s4;

	assign base  = $signed({2'b00, luma, 16'h0000});
	assign sum_r = base + prod.kr_v;
	assign sum_g = base - prod.kgv_v - prod.kgu_u;
	assign sum_b = base + prod.kb_u;

	assign gain_x = {{(yrd_pkg::ScaleW-yrd_pkg::GainW){1'b0}}, gain};

	// floor is the arithmetic drop of the 16 fraction bits
	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s2.red   <= yrd_pkg::clamp8(sum_r[yrd_pkg::ProdW-1:16]);
			clamp_s2.green <= yrd_pkg::clamp8(sum_g[yrd_pkg::ProdW-1:16]);
			clamp_s2.blue  <= yrd_pkg::clamp8(sum_b[yrd_pkg::ProdW-1:16]);
			scaled_s3.red   <= {{(yrd_pkg::ScaleW-8){1'b0}}, clamp_s2.red} * gain_x;
			scaled_s3.green <= {{(yrd_pkg::ScaleW-8){1'b0}}, clamp_s2.green} * gain_x;
			scaled_s3.blue  <= {{(yrd_pkg::ScaleW-8){1'b0}}, clamp_s2.blue} * gain_x;
			rgb_s4.red   <= yrd_pkg::sat8(scaled_s3.red);
			rgb_s4.green <= yrd_pkg::sat8(scaled_s3.green);
			rgb_s4.blue  <= yrd_pkg::sat8(scaled_s3.blue);
		end
	end

	assign rgb = rgb_s4;

endmodule

FILE: rtl/yuyv_to_rgb_dimmed_unit.sv
// top level: yuyv 4:2:2 macropixel to two dimmed rgb888 pixels
// One macropixel is taken per clock unless halted, and two RGB pixels come out after
// chroma products, sum with floor and clamp, gain multiply, saturation. The whole
// pipeline moves together and halts only while the output holds a transfer that
// is not taken, so s_tready follows m_tready directly. output_gain resets to 220,
// is taken on cfg_valid every cycle and should be written while the pipeline is empty.
module yuyv_to_rgb_dimmed_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [yrd_pkg::GainW-1:0]  cfg_data,   // output_gain
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,    // luma_first, chroma_blue, luma_second, chroma_red
	input  logic                       s_tlast,    // frame_end_in
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [47:0]                m_tdata,    // red_first, green_first, blue_first,
	                                               // red_second, green_second, blue_second
	output logic                       m_tlast     // frame_end_out
);

	logic                             en;
	logic [yrd_pkg::GainW-1:0]        gain_q;
	logic signed [yrd_pkg::ProdW-1:0] du;
	logic signed [yrd_pkg::ProdW-1:0] dv;

	yrd_pkg::prod_t prod_s1;
	logic [7:0]     luma0_s1;
	logic [7:0]     luma1_s1;
	logic           vld_s1, vld_s2, vld_s3, vld_s4;
	logic           last_s1, last_s2, last_s3, last_s4;
	yrd_pkg::rgb_t  rgb0;
	yrd_pkg::rgb_t  rgb1;

	assign en        = !vld_s4 || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= yrd_pkg::GainReset;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// chroma offsets from 128
	assign du = $signed({{(yrd_pkg::ProdW-8){1'b0}}, s_tdata[15:8]}) - 26'sd128;
	assign dv = $signed({{(yrd_pkg::ProdW-8){1'b0}}, s_tdata[31:24]}) - 26'sd128;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.kr_v  <= dv * yrd_pkg::CoefKr;
			prod_s1.kgv_v <= dv * yrd_pkg::CoefKgv;
			prod_s1.kgu_u <= du * yrd_pkg::CoefKgu;
			prod_s1.kb_u  <= du * yrd_pkg::CoefKb;
			luma0_s1 <= s_tdata[7:0];
			luma1_s1 <= s_tdata[23:16];
			last_s1  <= s_tlast;
			last_s2  <= last_s1;
			last_s3  <= last_s2;
			last_s4  <= last_s3;
		end
	end

	yrd_pixel u_pixel0 (
		.clk  (clk),
		.en   (en),
		.luma (luma0_s1),
		.prod (prod_s1),
		.gain (gain_q),
		.rgb  (rgb0)
	);

	yrd_pixel u_pixel1 (
		.clk  (clk),
		.en   (en),
		.luma (luma1_s1),
		.prod (prod_s1),
		.gain (gain_q),
		.rgb  (rgb1)
	);

	assign m_tvalid = vld_s4;
	assign m_tlast  = last_s4;
	assign m_tdata  = {rgb1.blue, rgb1.green, rgb1.red, rgb0.blue, rgb0.green, rgb0.red};

endmodule

FILE: rtl/yrd_checker.sv
// port-level checks for the converter, bound to the top level
module yrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output transfer dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output data changed while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled while output side is free");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_tvalid && s_tready && s_tlast, 4) && $past(m_tready, 1) &&
		$past(m_tready, 2) && $past(m_tready, 3) && $past(arst_n, 1) &&
		$past(arst_n, 2) && $past(arst_n, 3) && $past(arst_n, 4)
		|-> m_tvalid && m_tlast)
		else $error("frame end not delivered four cycles after transfer");

endmodule

bind yuyv_to_rgb_dimmed_unit yrd_checker u_yrd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
